// ===== rtl/ptc_pkg.sv =====
// Package: shared types, constants and fixed-point helpers for the compensation block.
`default_nettype none
package ptc_pkg;

  localparam int unsigned CalibW   = 48;
  localparam int unsigned RawW     = 20;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [CfgIdxW-1:0] RegTempCalib  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressCalibA = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressCalibB = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressCalibC = 2'd3;

  localparam logic [31:0] Offset64000 = 32'd64000;
  localparam logic [31:0] Full1048576 = 32'd1048576;
  localparam logic [31:0] Scale3125   = 32'd3125;
  localparam logic [31:0] Half32768   = 32'd32768;
  localparam logic [31:0] Round128    = 32'd128;

  // Item handed from the front part to the back part through the queue.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] numer;   // scaled dividend before the divide
    logic [31:0] divisor;
    logic        big;     // dividend has bit 31 set: divide first, then double
    logic        zero;
  } front_item_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    asr = 32'($signed(x) >>> s);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ptc_front.sv =====
// Front part: temperature and divisor/dividend pipeline, eight register stages.
`default_nettype none
module ptc_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        en,
  input  wire                        in_vld,
  input  wire [ptc_pkg::RawW-1:0]    raw_t,
  input  wire [ptc_pkg::RawW-1:0]    raw_p,
  input  wire [ptc_pkg::CalibW-1:0]  tcal,
  input  wire [ptc_pkg::CalibW-1:0]  pcal_a,
  input  wire [ptc_pkg::CalibW-1:0]  pcal_b,
  output logic                       out_vld,
  output ptc_pkg::front_item_t       out_item
);
  localparam int unsigned Stages = 6;

  logic [Stages-1:0] vld_r;

  // stage 1
  logic [31:0] s1_a_r, s1_d_r;
  logic [19:0] s1_p_r;
  // stage 2
  logic [31:0] s2_a_r, s2_dd_r;
  logic [19:0] s2_p_r;
  // stage 3
  logic [31:0] s3_tf_r;
  logic [19:0] s3_p_r;
  // stage 4
  logic [31:0] s4_temp_r, s4_v1_r, s4_sq_r, s4_p5_r, s4_p2_r;
  logic [19:0] s4_p_r;
  // stage 5
  logic [31:0] s5_temp_r, s5_p6_r, s5_p3_r, s5_p5_r, s5_p2_r;
  logic [19:0] s5_p_r;
  // stage 6 (two steps folded into register pairs below)
  logic [31:0] s6_temp_r, s6_v2_r, s6_v1_r;
  logic [19:0] s6_p_r;
  // stage 7/8
  logic [31:0] s7_temp_r, s7_x_r, s7_div_r;
  logic [31:0] s8_temp_r, s8_c_r, s8_div_r;

  logic [31:0] t1, t2, t3;
  logic [31:0] v1c, v2c, v1b;

  always_comb begin
    t1 = {16'd0, tcal[15:0]};
    t2 = ptc_pkg::sx16(tcal[31:16]);
    t3 = ptc_pkg::sx16(tcal[47:32]);
    v2c = ptc_pkg::asr(s5_p6_r + (s5_p5_r << 1), 2) + (ptc_pkg::sx16(pcal_b[15:0]) << 16);
    v1c = ptc_pkg::asr(ptc_pkg::asr(s5_p3_r, 3) + ptc_pkg::asr(s5_p2_r, 1), 18);
    v1b = 32'(({16'd0, pcal_a[15:0]}) * (ptc_pkg::Half32768 + s6_v1_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Stages-2:0], in_vld};
    end
  end

  logic [31:0] dtmp;
  assign dtmp = {16'd0, raw_t[19:4]} - t1;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r  <= {12'd0, 3'd0, raw_t[19:3]} - (t1 << 1);
      s1_d_r  <= dtmp;
      s1_p_r  <= raw_p;
      s2_a_r  <= ptc_pkg::asr(32'(s1_a_r * t2), 11);
      s2_dd_r <= ptc_pkg::asr(32'(s1_d_r * s1_d_r), 12);
      s2_p_r  <= s1_p_r;
      s3_tf_r <= s2_a_r + ptc_pkg::asr(32'(s2_dd_r * t3), 14);
      s3_p_r  <= s2_p_r;
      s4_temp_r <= ptc_pkg::asr(32'(s3_tf_r * 32'd5) + ptc_pkg::Round128, 8);
      s4_v1_r <= ptc_pkg::asr(s3_tf_r, 1) - ptc_pkg::Offset64000;
      s4_sq_r <= 32'(ptc_pkg::asr(ptc_pkg::asr(s3_tf_r, 1) - ptc_pkg::Offset64000, 2)
                 * ptc_pkg::asr(ptc_pkg::asr(s3_tf_r, 1) - ptc_pkg::Offset64000, 2));
      s4_p_r  <= s3_p_r;
      s5_temp_r <= s4_temp_r;
      s5_p6_r <= 32'(ptc_pkg::asr(s4_sq_r, 11) * ptc_pkg::sx16(pcal_b[47:32]));
      s5_p5_r <= 32'(s4_v1_r * ptc_pkg::sx16(pcal_b[31:16]));
      s5_p3_r <= 32'(ptc_pkg::sx16(pcal_a[47:32]) * ptc_pkg::asr(s4_sq_r, 13));
      s5_p2_r <= 32'(ptc_pkg::sx16(pcal_a[31:16]) * s4_v1_r);
      s5_p_r  <= s4_p_r;
      s6_temp_r <= s5_temp_r;
      s6_v2_r <= v2c;
      s6_v1_r <= v1c;
      s6_p_r  <= s5_p_r;
    end
  end

  // Last two steps run on their own registers, gated by the same enable.
  logic vld7_r, vld8_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
    end else if (en) begin
      vld7_r <= vld_r[Stages-1];
      vld8_r <= vld7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_temp_r <= s6_temp_r;
      s7_x_r    <= (ptc_pkg::Full1048576 - {12'd0, s6_p_r}) - ptc_pkg::asr(s6_v2_r, 12);
      s7_div_r  <= ptc_pkg::asr(v1b, 15);
      s8_temp_r <= s7_temp_r;
      s8_c_r    <= 32'(s7_x_r * ptc_pkg::Scale3125);
      s8_div_r  <= s7_div_r;
    end
  end

  assign out_vld = vld8_r;
  always_comb begin
    out_item.temp    = s8_temp_r;
    out_item.big     = s8_c_r[31];
    out_item.numer   = s8_c_r[31] ? s8_c_r : (s8_c_r << 1);
    out_item.divisor = s8_div_r;
    out_item.zero    = (s8_div_r == 32'd0);
  end
endmodule
`default_nettype wire

// ===== rtl/ptc_queue.sv =====
// Short queue between front and back parts.
`default_nettype none
module ptc_queue #(
  parameter int unsigned Depth = ptc_pkg::QueueDepthDef
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   wr_en,
  input  wire ptc_pkg::front_item_t wr_item,
  input  wire                   rd_en,
  output ptc_pkg::front_item_t  rd_item,
  output logic                  not_empty,
  output logic [$clog2(Depth+1)-1:0] count
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth+1);

  ptc_pkg::front_item_t mem_r [Depth];
  ptc_pkg::front_item_t rd_item_r;
  logic [AW-1:0] wp_r, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(Depth-1)) ? '0 : p + AW'(1);
  endfunction

  assign rp_nxt = rd_en ? inc(rp_r) : rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= inc(wp_r);
      rp_r <= rp_nxt;
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

  // Register the head entry; pass a same-edge write to that slot straight through.
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
    if (wr_en && (wp_r == rp_nxt)) begin
      rd_item_r <= wr_item;
    end else begin
      rd_item_r <= mem_r[rp_nxt];
    end
  end

  assign rd_item = rd_item_r;
  assign not_empty = (cnt_r != '0);
  assign count = cnt_r;
endmodule
`default_nettype wire

// ===== rtl/ptc_back.sv =====
// Back part: pipelined 32-bit divider and final pressure terms.
`default_nettype none
module ptc_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  wire                   in_vld,
  input  wire ptc_pkg::front_item_t in_item,
  input  wire [ptc_pkg::CalibW-1:0] pcal_c,
  output logic                  out_vld,
  output logic [31:0]           out_temp,
  output logic [31:0]           out_pres,
  output logic                  out_zero
);
  localparam int unsigned Steps = 32;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned DivStages = Steps / BitsPerStage;
  localparam int unsigned Last = DivStages - 1;

  logic [DivStages-1:0]    dv_r;
  logic [31:0]             rem_r  [DivStages];
  logic [31:0]             quo_r  [DivStages];
  logic [31:0]             num_r  [DivStages];
  logic [31:0]             den_r  [DivStages];
  logic [31:0]             tmp_r  [DivStages];
  logic                    big_r  [DivStages];
  logic                    zero_r [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic        v_in, big_in, zero_in;
    logic [31:0] rem_in, quo_in, num_in, den_in, tmp_in;
    logic [32:0] r;
    logic [31:0] q, n;
    if (g == 0) begin : g_head
      assign v_in    = in_vld;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = in_item.numer;
      assign den_in  = in_item.divisor;
      assign tmp_in  = in_item.temp;
      assign big_in  = in_item.big;
      assign zero_in = in_item.zero;
    end else begin : g_body
      assign v_in    = dv_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign num_in  = num_r[g-1];
      assign den_in  = den_r[g-1];
      assign tmp_in  = tmp_r[g-1];
      assign big_in  = big_r[g-1];
      assign zero_in = zero_r[g-1];
    end
    always_comb begin
      r = {1'b0, rem_in};
      q = quo_in;
      n = num_in;
      for (int b = 0; b < BitsPerStage; b++) begin
        r = {r[31:0], n[31]};
        n = n << 1;
        if (r >= {1'b0, den_in}) begin
          r = r - {1'b0, den_in};
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g] <= 1'b0;
      end else if (en) begin
        dv_r[g] <= v_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= r[31:0];
        quo_r[g]  <= q;
        num_r[g]  <= n;
        den_r[g]  <= den_in;
        tmp_r[g]  <= tmp_in;
        big_r[g]  <= big_in;
        zero_r[g] <= zero_in;
      end
    end
  end

  logic [31:0] c;
  assign c = big_r[Last] ? (quo_r[Last] << 1) : quo_r[Last];

  // tail: square, two products, sum
  logic        t1_vld_r, t2_vld_r, t3_vld_r;
  logic [31:0] t1_c_r, t1_sq_r, t1_temp_r; logic t1_zero_r;
  logic [31:0] t2_c_r, t2_a_r, t2_b_r, t2_temp_r; logic t2_zero_r;
  logic [31:0] t3_p_r, t3_temp_r; logic t3_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r <= dv_r[Last];
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_c_r    <= c;
      t1_sq_r   <= 32'((c >> 3) * (c >> 3));
      t1_temp_r <= tmp_r[Last];
      t1_zero_r <= zero_r[Last];
      t2_c_r    <= t1_c_r;
      t2_a_r    <= ptc_pkg::asr(32'(ptc_pkg::sx16(pcal_c[47:32]) * (t1_sq_r >> 13)), 12);
      t2_b_r    <= ptc_pkg::asr(32'((t1_c_r >> 2) * ptc_pkg::sx16(pcal_c[31:16])), 13);
      t2_temp_r <= t1_temp_r;
      t2_zero_r <= t1_zero_r;
      t3_p_r    <= t2_zero_r ? 32'd0 :
                   t2_c_r + ptc_pkg::asr(t2_a_r + t2_b_r + ptc_pkg::sx16(pcal_c[15:0]), 4);
      t3_temp_r <= t2_temp_r;
      t3_zero_r <= t2_zero_r;
    end
  end

  assign out_vld  = t3_vld_r;
  assign out_temp = t3_temp_r;
  assign out_pres = t3_p_r;
  assign out_zero = t3_zero_r;
endmodule
`default_nettype wire

// ===== rtl/pressure_temp_compensation.sv =====
// Top level: barometric compensation with front pipeline, queue and divider back end.
//
//  Channel | Dir | Handshake            | Payload
//  in_     | in  | in_tvalid/in_tready  | tdata[19:0] raw_temperature, [39:20] raw_press
//  out_    | out | out_tvalid/out_tready| tdata[31:0] temperature_centi, [63:32] pressure_pa;
//          |     |                      | tuser divisor_zero
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index (2 bits), cfg_data (48 bits)
//
// One item per cycle while out_tready holds; items pass front, queue, divider and tail.
// The 32-step restoring divide, four bits per stage, sets the depth of the back part.
// Reset (synchronous, rst_n low) clears calibration, all valid bits and the queue.
// The front pipeline runs freely; input is accepted only while the queue has room for
// every item in flight. The back pipeline advances while its output register is free
// or being taken.
`default_nettype none
module pressure_temp_compensation #(
  parameter int unsigned QueueDepth = ptc_pkg::QueueDepthDef + 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [ptc_pkg::InDataW-1:0]      in_tdata,   // raw_temperature, raw_press
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [ptc_pkg::OutDataW-1:0]     out_tdata,  // temperature_centi, pressure_pa
  output logic                             out_tuser,  // divisor_zero
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [ptc_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire  [ptc_pkg::CalibW-1:0]       cfg_data
);
  localparam int unsigned CW = $clog2(QueueDepth+1);

  logic [ptc_pkg::CalibW-1:0] tcal_r, pa_r, pb_r, pc_r;

  // Always ready; write registers only while no item is in flight.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0;
      pa_r   <= '0;
      pb_r   <= '0;
      pc_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptc_pkg::RegTempCalib:   tcal_r <= cfg_data;
        ptc_pkg::RegPressCalibA: pa_r   <= cfg_data;
        ptc_pkg::RegPressCalibB: pb_r   <= cfg_data;
        ptc_pkg::RegPressCalibC: pc_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Count items inside the front pipeline so the queue never overflows.
  logic [CW-1:0] inflight_r, q_count;
  logic          f_vld, q_ne, b_en, q_rd;
  ptc_pkg::front_item_t f_item, q_item;
  logic          in_acc;

  assign in_tready = (32'(inflight_r) + 32'(q_count)) < QueueDepth;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + CW'(in_acc) - CW'(f_vld);
    end
  end

  // Front runs freely: each accepted item already has a queue slot reserved.
  ptc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (1'b1),
    .in_vld  (in_acc),
    .raw_t   (in_tdata[19:0]),
    .raw_p   (in_tdata[39:20]),
    .tcal    (tcal_r),
    .pcal_a  (pa_r),
    .pcal_b  (pb_r),
    .out_vld (f_vld),
    .out_item(f_item)
  );

  ptc_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_vld),
    .wr_item  (f_item),
    .rd_en    (q_rd),
    .rd_item  (q_item),
    .not_empty(q_ne),
    .count    (q_count)
  );

  // Back stalls as a whole while a finished result waits.
  assign b_en = !out_tvalid || out_tready;
  assign q_rd = b_en && q_ne;

  logic [31:0] b_temp, b_pres;
  logic        b_zero;

  ptc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (b_en),
    .in_vld  (q_rd),
    .in_item (q_item),
    .pcal_c  (pc_r),
    .out_vld (out_tvalid),
    .out_temp(b_temp),
    .out_pres(b_pres),
    .out_zero(b_zero)
  );

  assign out_tdata = {b_pres, b_temp};
  assign out_tuser = b_zero;
endmodule
`default_nettype wire
